// ===== rtl/mrf_pkg.sv =====
`default_nettype none
package mrf_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned BodyLen  = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [15:0] register_value;
    logic [15:0] register_address;
    logic [7:0]  function_code;
    logic [7:0]  slave_address;
  } req_t;

  // body bytes in frame order
  function automatic logic [7:0] body_byte(req_t req, int unsigned idx);
    logic [7:0] b;
    case (idx)
      0:       b = req.slave_address;
      1:       b = req.function_code;
      2:       b = req.register_address[15:8];
      3:       b = req.register_address[7:0];
      4:       b = req.register_value[15:8];
      default: b = req.register_value[7:0];
    endcase
    return b;
  endfunction

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mrf_crc_stage.sv =====
`default_nettype none
module mrf_crc_stage #(
  parameter int unsigned ByteIdx = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire mrf_pkg::req_t req_i,
  input  wire logic [15:0]   crc_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output mrf_pkg::req_t      req_o,
  output logic [15:0]        crc_o
);

  logic          valid_q;
  mrf_pkg::req_t req_q;
  logic [15:0]   crc_q;
  logic [15:0]   crc_d;

  assign ready_o = !valid_q || ready_i;
  assign crc_d   = mrf_pkg::crc16_byte(crc_i, mrf_pkg::body_byte(req_i, ByteIdx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
      crc_q <= crc_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;
  assign crc_o   = crc_q;

endmodule
`default_nettype wire

// ===== rtl/mrf_serializer.sv =====
`default_nettype none
module mrf_serializer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          crc_low_first_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire mrf_pkg::req_t req_i,
  input  wire logic [15:0]   crc_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [7:0]         byte_o,
  output logic               last_o
);

  localparam int unsigned FrameW = mrf_pkg::FrameLen * mrf_pkg::ByteW;
  localparam logic [mrf_pkg::CntW-1:0] LastCnt = mrf_pkg::CntW'(mrf_pkg::FrameLen - 1);

  logic                      valid_q;
  logic [mrf_pkg::CntW-1:0]  cnt_q;
  logic [FrameW-1:0]         frame_q;
  logic [FrameW-1:0]         frame_d;
  logic [15:0]               crc_tx;
  logic                      last;
  logic                      load;

  assign last    = (cnt_q == LastCnt);
  // next frame loads in the cycle its predecessor's last word leaves
  assign ready_o = !valid_q || (ready_i && last);
  assign load    = valid_i && ready_o;

  // crc bytes as they go on the wire, first byte in the low half
  assign crc_tx  = crc_low_first_i ? crc_i : {crc_i[7:0], crc_i[15:8]};
  assign frame_d = {crc_tx,
                    req_i.register_value[7:0], req_i.register_value[15:8],
                    req_i.register_address[7:0], req_i.register_address[15:8],
                    req_i.function_code, req_i.slave_address};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (valid_q && ready_i) begin
      if (last) begin
        valid_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end else if (valid_q && ready_i) begin
      frame_q <= frame_q >> mrf_pkg::ByteW;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = frame_q[mrf_pkg::ByteW-1:0];
  assign last_o  = last;

endmodule
`default_nettype wire

// ===== rtl/modbus_request_framer_crc16.sv =====
// channel   dir  signals                              content
// s_axis    in   s_axis_tvalid/tready/tdata[47:0]     one request word
// m_axis    out  m_axis_tvalid/tready/tdata[7:0]/tlast one frame byte, tlast on byte 8
// cfg       in   cfg_valid_i/cfg_ready_o/cfg_data_i    crc byte order (1 = low first)
//
// six crc stages, one frame byte each, then an 8-byte shift register to the output.
// at the output port the serializer sends one byte per cycle while m_axis_tready is high
// and loads the next frame on the cycle the current last byte is taken.
// first byte reaches m_axis after the request passes the six crc stage registers.
// reset clears the valid bits and sets crc order to high byte first.
// a stall on m_axis holds each stage in place; stages with a hole still advance.
`default_nettype none
module modbus_request_framer_crc16 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // slave_address[7:0], function_code[15:8], register_address[31:16],
  // register_value[47:32]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int unsigned NStg = mrf_pkg::BodyLen;

  logic          crc_low_first_q;
  logic          valid   [NStg+1];
  logic          ready   [NStg+1];
  mrf_pkg::req_t req     [NStg+1];
  logic [15:0]   crc     [NStg+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_low_first_q <= 1'b0;
    end else if (cfg_valid_i) begin
      crc_low_first_q <= cfg_data_i;
    end
  end

  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign req[0]        = mrf_pkg::req_t'(s_axis_tdata);
  assign crc[0]        = mrf_pkg::CrcInit;

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    mrf_crc_stage #(
      .ByteIdx(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[g]),
      .ready_o(ready[g]),
      .req_i  (req[g]),
      .crc_i  (crc[g]),
      .valid_o(valid[g+1]),
      .ready_i(ready[g+1]),
      .req_o  (req[g+1]),
      .crc_o  (crc[g+1])
    );
  end

  mrf_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .crc_low_first_i(crc_low_first_q),
    .valid_i        (valid[NStg]),
    .ready_o        (ready[NStg]),
    .req_i          (req[NStg]),
    .crc_i          (crc[NStg]),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .byte_o         (m_axis_tdata),
    .last_o         (m_axis_tlast)
  );

endmodule
`default_nettype wire
